>>> rtl/dqber_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_pkg: shared types and constants
// Widths, fixed-point constants and small tables for the DQPSK BER step unit.
// ----------------------------------------------------------------------------
package dqber_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 32;

	localparam int UNIFORM_W     = 16;
	localparam int NOISE_SCALE_W = 16;
	localparam logic [NOISE_SCALE_W-1:0] NOISE_SCALE_RST = 16'd32768;

	// APB map: one register, 32-bit data, index in paddr[2]
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_NOISE_SCALE = 1'b0;

	// noise datapath widths
	localparam int RADIUS_W = 19;
	localparam int TRIG_W   = 17;
	localparam int PROD1_W  = RADIUS_W + TRIG_W;
	localparam int PROD_W   = PROD1_W + NOISE_SCALE_W;
	localparam int ANG_W    = 30;
	localparam int RCP_W    = 32;
	localparam int RSH_W    = 6;

	localparam logic [16:0] TWO_LN2_Q16    = 17'd90852;
	localparam logic [16:0] ANGLE_STEP_Q30 = 17'd102944;

	localparam int LOG_ROUNDS  = 16;
	localparam int SQRT_ROUNDS = 19;
	localparam int POW_STEPS   = 7;
	localparam int DIV_TERMS   = 6;

	// ceil(2^k / d) with k = 30 + ceil(log2 d): floor division of any
	// 30-bit term by d is (term * recip) >> k
	localparam logic [63:0] RCP_T3 = ((64'd1 << 33) + 64'd5) / 64'd6;
	localparam logic [63:0] RCP_T5 = ((64'd1 << 37) + 64'd119) / 64'd120;
	localparam logic [63:0] RCP_T7 = ((64'd1 << 43) + 64'd5039) / 64'd5040;
	localparam logic [63:0] RCP_T4 = ((64'd1 << 35) + 64'd23) / 64'd24;
	localparam logic [63:0] RCP_T6 = ((64'd1 << 40) + 64'd719) / 64'd720;
	localparam logic [63:0] RCP_T8 = ((64'd1 << 46) + 64'd40319) / 64'd40320;

	typedef struct packed {
		logic bit_i;
		logic bit_q;
		logic new_run;
	} sym_t;

	typedef enum logic [1:0] {
		SGN_ZERO = 2'b00,
		SGN_POS  = 2'b01,
		SGN_NEG  = 2'b10
	} sgn_t;

	// Taylor terms in order t3, t5, t7, t4, t6, t8
	function automatic logic [RCP_W-1:0] recip_const(input logic [2:0] idx);
		logic [RCP_W-1:0] r;
		unique case (idx)
			3'd0:    r = RCP_T3[RCP_W-1:0];
			3'd1:    r = RCP_T5[RCP_W-1:0];
			3'd2:    r = RCP_T7[RCP_W-1:0];
			3'd3:    r = RCP_T4[RCP_W-1:0];
			3'd4:    r = RCP_T6[RCP_W-1:0];
			3'd5:    r = RCP_T8[RCP_W-1:0];
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [RSH_W-1:0] recip_shift(input logic [2:0] idx);
		logic [RSH_W-1:0] s;
		unique case (idx)
			3'd0:    s = 6'd33;
			3'd1:    s = 6'd37;
			3'd2:    s = 6'd43;
			3'd3:    s = 6'd35;
			3'd4:    s = 6'd40;
			3'd5:    s = 6'd46;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

	function automatic sgn_t cos_sign(input logic [2:0] ph);
		sgn_t s;
		unique case (ph) inside
			3'd0, 3'd1, 3'd7: s = SGN_POS;
			3'd2, 3'd6:       s = SGN_ZERO;
			default:          s = SGN_NEG;
		endcase
		return s;
	endfunction

	function automatic sgn_t sin_sign(input logic [2:0] ph);
		sgn_t s;
		unique case (ph) inside
			3'd0, 3'd4:       s = SGN_ZERO;
			3'd1, 3'd2, 3'd3: s = SGN_POS;
			default:          s = SGN_NEG;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

>>> rtl/dqber_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_in_if: symbol input channel
// Valid/ready channel carrying data bits, uniforms and the new-run flag.
// ----------------------------------------------------------------------------
interface dqber_in_if import dqber_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 bit_i;
	logic                 bit_q;
	logic [UNIFORM_W-1:0] uniform_a;
	logic [UNIFORM_W-1:0] uniform_b;
	logic                 new_run;

	modport source (output valid, bit_i, bit_q, uniform_a, uniform_b, new_run, input ready);
	modport sink   (input valid, bit_i, bit_q, uniform_a, uniform_b, new_run, output ready);
endinterface
`default_nettype wire

>>> rtl/dqber_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_out_if: result output channel
// Valid/ready channel carrying received sample, decisions and error counts.
// ----------------------------------------------------------------------------
interface dqber_out_if import dqber_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] rx_i;
	logic signed [SAMPLE_WIDTH-1:0] rx_q;
	logic                           decided_i;
	logic                           decided_q;
	logic [1:0]                     symbol_errors;
	logic [COUNT_WIDTH-1:0]         error_total;

	modport source (output valid, rx_i, rx_q, decided_i, decided_q, symbol_errors,
		error_total, input ready);
	modport sink   (input valid, rx_i, rx_q, decided_i, decided_q, symbol_errors,
		error_total, output ready);
endinterface
`default_nettype wire

>>> rtl/dqpsk_awgn_ber_symbol_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqpsk_awgn_ber_symbol_step_unit: DQPSK modem with AWGN and BER counter
// Top level: APB register, noise front end, item queue, detection back end.
// ----------------------------------------------------------------------------
// One item is one DQPSK symbol: two data bits, two 16-bit uniforms and a
// new-run flag. The front end takes an item when idle and works on it in
// order: it takes it, runs the log rounds, a multiply, the square-root
// rounds, an angle multiply, the Taylor powers, reciprocal multiplies for
// the six series terms, a combine, the scaling and the hand-over of the
// noise pair to the queue; the log and square-root rounds are the bulk of
// the time. An item with a zero uniform is dropped in its accept cycle and
// gives no result. The back end adds the noise to the transmitted point,
// detects differentially and counts errors in a 3-stage pipeline; a
// two-entry queue lets the front end start the next item while a result
// waits on the output. noise_scale sits at APB byte address 0 and should
// be written only while the unit is idle.
// ----------------------------------------------------------------------------
module dqpsk_awgn_ber_symbol_step_unit import dqber_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	dqber_in_if.sink                   in_ch,
	dqber_out_if.source                out_ch
);
	localparam int NW = SAMPLE_WIDTH + 2;
	localparam int QW = $bits(sym_t) + 2 * NW;

	logic [NOISE_SCALE_W-1:0] noise_scale_q;

	sym_t                 in_sym;
	logic                 f_valid, f_ready;
	sym_t                 f_sym;
	logic signed [NW-1:0] f_ni, f_nq;
	logic [QW-1:0]        q_in, q_out;
	logic                 b_valid, b_ready;
	sym_t                 b_sym;
	logic signed [NW-1:0] b_ni, b_nq;

	// APB: single register, index in paddr[2], zero wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_scale_q <= NOISE_SCALE_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_NOISE_SCALE) begin
			noise_scale_q <= pwdata[NOISE_SCALE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_NOISE_SCALE) begin
			prdata[NOISE_SCALE_W-1:0] = noise_scale_q;
		end
	end

	assign in_sym = '{bit_i: in_ch.bit_i, bit_q: in_ch.bit_q, new_run: in_ch.new_run};

	// noise generator
	dqber_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_sym      (in_sym),
		.uniform_a   (in_ch.uniform_a),
		.uniform_b   (in_ch.uniform_b),
		.noise_scale (noise_scale_q),
		.push_valid  (f_valid),
		.push_ready  (f_ready),
		.push_sym    (f_sym),
		.push_ni     (f_ni),
		.push_nq     (f_nq)
	);

	assign q_in = {f_sym, f_ni, f_nq};

	dqber_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_in),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_out)
	);

	assign b_sym = sym_t'(q_out[QW-1 -: $bits(sym_t)]);
	assign b_ni  = $signed(q_out[2*NW-1 -: NW]);
	assign b_nq  = $signed(q_out[NW-1:0]);

	// channel state, detection and counting
	dqber_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (b_valid),
		.q_ready       (b_ready),
		.q_sym         (b_sym),
		.q_ni          (b_ni),
		.q_nq          (b_nq),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.rx_i          (out_ch.rx_i),
		.rx_q          (out_ch.rx_q),
		.decided_i     (out_ch.decided_i),
		.decided_q     (out_ch.decided_q),
		.symbol_errors (out_ch.symbol_errors),
		.error_total   (out_ch.error_total)
	);

endmodule
`default_nettype wire

>>> rtl/dqber_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_front: item intake and Box-Muller noise generator
// Drops items with a zero uniform, then builds one noise pair per item with
// serial log, square root, Taylor power and reciprocal-multiply steps.
// ----------------------------------------------------------------------------
module dqber_front import dqber_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire sym_t                          in_sym,
	input  wire logic [UNIFORM_W-1:0]          uniform_a,
	input  wire logic [UNIFORM_W-1:0]          uniform_b,
	input  wire logic [NOISE_SCALE_W-1:0]      noise_scale,
	output logic                               push_valid,
	input  wire logic                          push_ready,
	output sym_t                               push_sym,
	output logic signed [SAMPLE_WIDTH+1:0]     push_ni,
	output logic signed [SAMPLE_WIDTH+1:0]     push_nq
);
	localparam int NW    = SAMPLE_WIDTH + 2;
	localparam int MAG_W = SAMPLE_WIDTH + 1;
	localparam int NS    = PROD_W - SAMPLE_WIDTH;

	typedef enum logic [10:0] {
		F_IDLE  = 11'b00000000001,
		F_LOG   = 11'b00000000010,
		F_RMUL  = 11'b00000000100,
		F_SQRT  = 11'b00000001000,
		F_THETA = 11'b00000010000,
		F_POW   = 11'b00000100000,
		F_DIV   = 11'b00001000000,
		F_TRIG  = 11'b00010000000,
		F_SCL1  = 11'b00100000000,
		F_SCL2  = 11'b01000000000,
		F_PUSH  = 11'b10000000000
	} fstate_t;

	fstate_t state_q, state_d;
	logic [4:0] step_q, step_d;
	logic [2:0] term_q, term_d;
	logic       sel_q, sel_d;
	logic       accept;

	// payload registers
	sym_t                   sym_q;
	logic [UNIFORM_W-1:0]   ub_q;
	logic [3:0]             e_q;
	logic [15:0]            m_q;
	logic [15:0]            frac_q;
	logic [37:0]            rad_q;
	logic [19:0]            rem_q;
	logic [RADIUS_W-1:0]    root_q;
	logic [ANG_W-1:0]       th_q;
	logic                   swap_q;
	logic [ANG_W-1:0]       t2_q, t3_q, t4_q, t5_q, t6_q, t7_q, t8_q;
	logic [ANG_W-1:0]       q3_q, q4_q, q5_q, q6_q, q7_q, q8_q;
	logic [TRIG_W-1:0]      ca_q, sa_q;
	logic                   cn_q, sn_q;
	logic [PROD1_W-1:0]     prod1_q;
	logic signed [NW-1:0]   ni_q, nq_q;

	// combinational helpers
	logic [3:0]             lead;
	logic [15:0]            mnorm;
	logic [31:0]            sq;
	logic [16:0]            sqt;
	logic [20:0]            nl;
	logic [37:0]            nl_mul;
	logic [21:0]            v;
	logic [21:0]            rem_n, trial;
	logic                   rge;
	logic [13:0]            r_ang, x_ang;
	logic                   swap;
	logic [30:0]            th_full;
	logic [ANG_W-1:0]       pa, pb;
	logic [2*ANG_W-1:0]     pprod;
	logic [ANG_W-1:0]       dsel;
	logic [RCP_W-1:0]       rcp;
	logic [RSH_W-1:0]       rsh;
	logic [ANG_W+RCP_W-1:0] dprod;
	logic [ANG_W-1:0]       quot;
	logic signed [31:0]     sv, cv;
	logic [31:0]            svc, cvc;
	logic [TRIG_W-1:0]      s16, c16, cf, sf;
	logic [TRIG_W-1:0]      tsel;
	logic [PROD1_W-1:0]     prod1;
	logic [PROD_W-1:0]      p;
	logic [PROD_W:0]        psum, pshift;
	logic [MAG_W-1:0]       mag;
	logic signed [NW-1:0]   noise;

	assign accept     = in_valid && in_ready;
	assign in_ready   = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_sym   = sym_q;
	assign push_ni    = ni_q;
	assign push_nq    = nq_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		term_d  = term_q;
		sel_d   = sel_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && uniform_a != '0 && uniform_b != '0) begin
					state_d = F_LOG;
					step_d  = '0;
				end
			end
			F_LOG: begin
				if (step_q == 5'(LOG_ROUNDS - 1)) begin
					state_d = F_RMUL;
					step_d  = '0;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			F_RMUL: begin
				state_d = F_SQRT;
				step_d  = '0;
			end
			F_SQRT: begin
				if (step_q == 5'(SQRT_ROUNDS - 1)) begin
					state_d = F_THETA;
					step_d  = '0;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			F_THETA: begin
				state_d = F_POW;
				step_d  = '0;
			end
			F_POW: begin
				if (step_q == 5'(POW_STEPS - 1)) begin
					state_d = F_DIV;
					step_d  = '0;
					term_d  = '0;
				end else begin
					step_d = step_q + 5'd1;
				end
			end
			F_DIV: begin
				if (term_q == 3'(DIV_TERMS - 1)) begin
					state_d = F_TRIG;
				end else begin
					term_d = term_q + 3'd1;
				end
			end
			F_TRIG: begin
				state_d = F_SCL1;
				sel_d   = 1'b0;
			end
			F_SCL1: begin
				state_d = F_SCL2;
			end
			F_SCL2: begin
				if (sel_q) begin
					state_d = F_PUSH;
				end else begin
					sel_d   = 1'b1;
					state_d = F_SCL1;
				end
			end
			F_PUSH: begin
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			term_q  <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			term_q  <= term_d;
			sel_q   <= sel_d;
		end
	end

	// leading one of uniform_a and normalized mantissa
	always_comb begin
		lead = '0;
		for (int i = 0; i < UNIFORM_W; i++) begin
			if (uniform_a[i]) begin
				lead = 4'(i);
			end
		end
		mnorm = uniform_a << (4'd15 - lead);
	end

	// log2 fraction: square the mantissa, one bit per round
	assign sq  = m_q * m_q;
	assign sqt = sq[31:15];

	// -2 ln(u1) in Q16, then shifted up for the root
	assign nl     = 21'(1 << 20) - {1'b0, e_q, frac_q};
	assign nl_mul = nl * TWO_LN2_Q16;
	assign v      = nl_mul[37:16];

	// restoring square root, two radicand bits per round
	assign rem_n = {rem_q, rad_q[37:36]};
	assign trial = {1'b0, root_q, 2'b01};
	assign rge   = (rem_n >= trial);

	// fold angle into the first octant
	assign r_ang   = ub_q[13:0];
	assign swap    = (r_ang > 14'd8192);
	assign x_ang   = swap ? 14'(15'd16384 - {1'b0, r_ang}) : r_ang;
	assign th_full = x_ang * ANGLE_STEP_Q30;

	// shared power multiplier
	always_comb begin
		unique case (step_q[2:0])
			3'd0:    begin pa = th_q; pb = th_q; end
			3'd1:    begin pa = t2_q; pb = th_q; end
			3'd2:    begin pa = t2_q; pb = t2_q; end
			3'd3:    begin pa = t4_q; pb = th_q; end
			3'd4:    begin pa = t4_q; pb = t2_q; end
			3'd5:    begin pa = t6_q; pb = th_q; end
			default: begin pa = t4_q; pb = t4_q; end
		endcase
	end
	assign pprod = pa * pb;

	// series term divide: one reciprocal multiply per term
	always_comb begin
		case (term_q)
			3'd0:    dsel = t3_q;
			3'd1:    dsel = t5_q;
			3'd2:    dsel = t7_q;
			3'd3:    dsel = t4_q;
			3'd4:    dsel = t6_q;
			default: dsel = t8_q;
		endcase
	end
	assign rcp   = recip_const(term_q);
	assign rsh   = recip_shift(term_q);
	assign dprod = dsel * rcp;
	assign quot  = ANG_W'(dprod >> rsh);

	// series sums, clamp and round to Q16
	always_comb begin
		sv = $signed({2'b00, th_q}) - $signed({2'b00, q3_q})
			+ $signed({2'b00, q5_q}) - $signed({2'b00, q7_q});
		cv = $signed(32'd1 << 30) - $signed({3'b000, t2_q[ANG_W-1:1]})
			+ $signed({2'b00, q4_q}) - $signed({2'b00, q6_q}) + $signed({2'b00, q8_q});
		svc = sv[31] ? 32'd0 : 32'(sv);
		cvc = cv[31] ? 32'd0 : 32'(cv);
		s16 = TRIG_W'((svc + 32'd8192) >> 14);
		c16 = TRIG_W'((cvc + 32'd8192) >> 14);
		cf  = swap_q ? s16 : c16;
		sf  = swap_q ? c16 : s16;
	end

	// scaling: radius * trig, then * noise_scale with rounding
	assign tsel   = sel_q ? sa_q : ca_q;
	assign prod1  = root_q * tsel;
	assign p      = prod1_q * noise_scale;
	assign psum   = {1'b0, p} + ((PROD_W + 1)'(1) << (NS - 1));
	assign pshift = psum >> NS;
	assign mag    = pshift[MAG_W-1:0];
	assign noise  = (sel_q ? sn_q : cn_q) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					sym_q  <= in_sym;
					ub_q   <= uniform_b;
					e_q    <= lead;
					m_q    <= mnorm;
					frac_q <= '0;
				end
			end
			F_LOG: begin
				if (sqt[16]) begin
					m_q    <= sqt[16:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= sqt[15:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			F_RMUL: begin
				rad_q  <= {v, 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end
			F_SQRT: begin
				rad_q  <= {rad_q[35:0], 2'b00};
				rem_q  <= rge ? 20'(rem_n - trial) : 20'(rem_n);
				root_q <= {root_q[RADIUS_W-2:0], rge};
			end
			F_THETA: begin
				th_q   <= th_full[ANG_W-1:0];
				swap_q <= swap;
			end
			F_POW: begin
				case (step_q[2:0])
					3'd0:    t2_q <= pprod[2*ANG_W-1:ANG_W];
					3'd1:    t3_q <= pprod[2*ANG_W-1:ANG_W];
					3'd2:    t4_q <= pprod[2*ANG_W-1:ANG_W];
					3'd3:    t5_q <= pprod[2*ANG_W-1:ANG_W];
					3'd4:    t6_q <= pprod[2*ANG_W-1:ANG_W];
					3'd5:    t7_q <= pprod[2*ANG_W-1:ANG_W];
					default: t8_q <= pprod[2*ANG_W-1:ANG_W];
				endcase
			end
			F_DIV: begin
				case (term_q)
					3'd0:    q3_q <= quot;
					3'd1:    q5_q <= quot;
					3'd2:    q7_q <= quot;
					3'd3:    q4_q <= quot;
					3'd4:    q6_q <= quot;
					default: q8_q <= quot;
				endcase
			end
			F_TRIG: begin
				unique case (ub_q[15:14])
					2'd0:    begin ca_q <= cf; cn_q <= 1'b0; sa_q <= sf; sn_q <= 1'b0; end
					2'd1:    begin ca_q <= sf; cn_q <= 1'b1; sa_q <= cf; sn_q <= 1'b0; end
					2'd2:    begin ca_q <= cf; cn_q <= 1'b1; sa_q <= sf; sn_q <= 1'b1; end
					default: begin ca_q <= sf; cn_q <= 1'b0; sa_q <= cf; sn_q <= 1'b1; end
				endcase
			end
			F_SCL1: begin
				prod1_q <= prod1;
			end
			F_SCL2: begin
				if (sel_q) begin
					nq_q <= noise;
				end else begin
					ni_q <= noise;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/dqber_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_queue: two-entry item queue
// Decouples the noise front end from the detection back end.
// ----------------------------------------------------------------------------
module dqber_queue import dqber_pkg::*; #(
	parameter int WIDTH = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/dqber_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_back: modulation, differential detection and error counting
// Three-stage pipeline holding the phase, previous sample and error count.
// ----------------------------------------------------------------------------
module dqber_back import dqber_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	output logic                             q_ready,
	input  wire sym_t                        q_sym,
	input  wire logic signed [SAMPLE_WIDTH+1:0] q_ni,
	input  wire logic signed [SAMPLE_WIDTH+1:0] q_nq,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]   rx_i,
	output logic signed [SAMPLE_WIDTH-1:0]   rx_q,
	output logic                             decided_i,
	output logic                             decided_q,
	output logic [1:0]                       symbol_errors,
	output logic [COUNT_WIDTH-1:0]           error_total
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int NW = SAMPLE_WIDTH + 2;
	localparam int F  = SAMPLE_WIDTH - 4;
	localparam logic [63:0] HR64 = (64'd3037000500 + (64'd1 << (31 - F))) >> (32 - F);
	localparam logic signed [NW-1:0] HALF_ROOT = NW'(HR64);
	localparam logic signed [NW-1:0] ONE_S     = NW'(64'd1 << F);
	localparam logic signed [SW-1:0] ONE_SW    = SW'(64'd1 << F);

	logic adv, pop;

	// loop state
	logic [2:0]             phase_q;
	logic signed [SW-1:0]   prev_i_q, prev_q_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// pipeline
	logic                   v_s1, v_s2;
	sym_t                   sym_s1, sym_s2;
	logic signed [SW-1:0]   rxi_s1, rxq_s1, pi_s1, pq_s1;
	logic signed [SW-1:0]   rxi_s2, rxq_s2;
	logic signed [2*SW-1:0] pa_s2, pb_s2, pc_s2, pd_s2;

	logic [2:0]             ph_base, step, ph;
	logic signed [NW-1:0]   lvl, txi, txq;
	logic signed [NW:0]     sumi, sumq;
	logic signed [SW-1:0]   rxi, rxq, pi_b, pq_b;
	logic signed [2*SW:0]   re, im;
	logic                   di, dq;
	logic [1:0]             se;
	logic [COUNT_WIDTH-1:0] cbase;
	logic [COUNT_WIDTH:0]   csum;

	function automatic logic signed [SW-1:0] sat(input logic signed [SW+2:0] x);
		logic signed [SW-1:0] r;
		if (x[SW+2:SW-1] == '0 || x[SW+2:SW-1] == '1) begin
			r = x[SW-1:0];
		end else if (x[SW+2]) begin
			r = {1'b1, {(SW-1){1'b0}}};
		end else begin
			r = {1'b0, {(SW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [NW-1:0] level(input sgn_t s,
			input logic signed [NW-1:0] mag);
		logic signed [NW-1:0] r;
		unique case (s)
			SGN_POS: r = mag;
			SGN_NEG: r = -mag;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign adv     = !out_valid || out_ready;
	assign pop     = adv && q_valid;
	assign q_ready = adv;

	// stage 1: phase step, transmit level, noise add
	always_comb begin
		ph_base = q_sym.new_run ? 3'd0 : phase_q;
		step    = q_sym.bit_i ? (q_sym.bit_q ? 3'd1 : 3'd7) : (q_sym.bit_q ? 3'd3 : 3'd5);
		ph      = ph_base + step;
		lvl     = ph[0] ? HALF_ROOT : ONE_S;
		txi     = level(cos_sign(ph), lvl);
		txq     = level(sin_sign(ph), lvl);
		sumi    = $signed({txi[NW-1], txi}) + $signed({q_ni[NW-1], q_ni});
		sumq    = $signed({txq[NW-1], txq}) + $signed({q_nq[NW-1], q_nq});
		rxi     = sat(sumi);
		rxq     = sat(sumq);
		pi_b    = q_sym.new_run ? ONE_SW : prev_i_q;
		pq_b    = q_sym.new_run ? '0 : prev_q_q;
	end

	// stage 3: decisions and count
	always_comb begin
		re    = $signed({pa_s2[2*SW-1], pa_s2}) + $signed({pb_s2[2*SW-1], pb_s2});
		im    = $signed({pc_s2[2*SW-1], pc_s2}) - $signed({pd_s2[2*SW-1], pd_s2});
		di    = !re[2*SW];
		dq    = !im[2*SW];
		se    = 2'(di != sym_s2.bit_i) + 2'(dq != sym_s2.bit_q);
		cbase = sym_s2.new_run ? '0 : cnt_q;
		csum  = {1'b0, cbase} + (COUNT_WIDTH + 1)'(se);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			prev_i_q  <= ONE_SW;
			prev_q_q  <= '0;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= ph;
				prev_i_q <= rxi;
				prev_q_q <= rxq;
			end
			if (adv) begin
				v_s1      <= q_valid;
				v_s2      <= v_s1;
				out_valid <= v_s2;
				if (v_s2) begin
					cnt_q <= csum[COUNT_WIDTH] ? '1 : csum[COUNT_WIDTH-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sym_s1 <= q_sym;
			rxi_s1 <= rxi;
			rxq_s1 <= rxq;
			pi_s1  <= pi_b;
			pq_s1  <= pq_b;
			sym_s2 <= sym_s1;
			rxi_s2 <= rxi_s1;
			rxq_s2 <= rxq_s1;
			pa_s2  <= rxi_s1 * pi_s1;
			pb_s2  <= rxq_s1 * pq_s1;
			pc_s2  <= rxq_s1 * pi_s1;
			pd_s2  <= rxi_s1 * pq_s1;
			rx_i          <= rxi_s2;
			rx_q          <= rxq_s2;
			decided_i     <= di;
			decided_q     <= dq;
			symbol_errors <= se;
			error_total   <= csum[COUNT_WIDTH] ? '1 : csum[COUNT_WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

>>> rtl/dqber_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqber_checker: port-level checks for the DQPSK BER step unit
// Watches the result channel and the APB read data.
// ----------------------------------------------------------------------------
module dqber_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_symbol_errors,
	input wire logic        out_error_nz,
	input wire logic        out_hold_sig,
	input wire logic [15:0] prdata_hi
);
	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hold_sig))
		else $error("stalled result changed");

	// two bits per symbol at most
	a_se_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_symbol_errors != 2'd3)
		else $error("symbol error count out of range");

	// the running total includes this symbol's errors
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_symbol_errors != 2'd0 |-> out_error_nz)
		else $error("error total misses symbol errors");

	// only the 16-bit register is readable
	a_prdata: assert property (@(posedge clk) disable iff (!arst_n)
		prdata_hi == 16'd0)
		else $error("read data upper bits set");

endmodule

bind dqpsk_awgn_ber_symbol_step_unit dqber_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_symbol_errors (out_ch.symbol_errors),
	.out_error_nz      (|out_ch.error_total),
	.out_hold_sig      (^{out_ch.rx_i, out_ch.rx_q, out_ch.decided_i, out_ch.decided_q,
		out_ch.symbol_errors, out_ch.error_total}),
	.prdata_hi         (prdata[31:16])
);
`default_nettype wire

>>> verif/tb_dqpsk_awgn_ber_symbol_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_dqpsk_awgn_ber_symbol_step_unit: self-checking bench for the DQPSK BER unit
// Feeds symbols through valid/ready with bursts and gaps, stalls the result
// side, and checks every result against a bit-exact modem/noise predictor.
// ----------------------------------------------------------------------------
module tb_dqpsk_awgn_ber_symbol_step_unit;
	import dqber_pkg::*;

	localparam int SW        = SAMPLE_WIDTH_DEF;
	localparam int CW        = COUNT_WIDTH_DEF;
	localparam int FRAC      = SW - 4;
	localparam int NSHIFT    = 48 - FRAC;
	localparam int DRAIN_CYC = 300;        // covers the front end's time for one item
	localparam longint LIMIT = 3000000;
	localparam longint S_MAX = (64'sd1 <<< (SW - 1)) - 1;
	localparam longint S_MIN = -S_MAX - 1;
	localparam longint C_MAX = (64'sd1 <<< CW) - 1;
	localparam longint ONE_S = 64'sd1 <<< FRAC;
	localparam longint HROOT = (64'sd3037000500 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);

	// phase step codes, units of 45 degrees
	localparam logic [2:0] STEP_P45  = 3'd1;
	localparam logic [2:0] STEP_P135 = 3'd3;
	localparam logic [2:0] STEP_M135 = 3'd5;
	localparam logic [2:0] STEP_M45  = 3'd7;

	typedef struct {
		bit        bi;
		bit        bq;
		bit [15:0] ua;
		bit [15:0] ub;
		bit        nr;
	} symbol_t;

	typedef struct {
		logic signed [SW-1:0] rxi;
		logic signed [SW-1:0] rxq;
		logic                 di;
		logic                 dq;
		logic [1:0]           serr;
		logic [CW-1:0]        total;
	} decision_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	dqber_in_if  in_ch ();
	dqber_out_if out_ch ();

	dqpsk_awgn_ber_symbol_step_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	// predictor state, mirrors the unit
	int unsigned scale_shadow;
	bit [2:0]    phase_acc;
	longint      last_rxi, last_rxq;
	longint      err_count;

	symbol_t   pending_syms[$];
	decision_t rx_expected[$];
	bit        failed;
	longint    cycle_cnt;

	int cos_sgn[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
	int sin_sgn[8] = '{0, 1, 1, 1, 0, -1, -1, -1};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------- predictor ----------------

	// -log2(a/65536) in Q16, by repeated squaring of the normalized mantissa
	function automatic longint unsigned neg_log2(input bit [15:0] a);
		int unsigned e;
		longint unsigned m, frac;
		e = 15;
		frac = 0;
		while (e > 0 && a[e] == 1'b0)
			e--;
		m = longint'(a) << (15 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 15;
			frac = frac << 1;
			if (m >= 65536) begin
				frac |= 1;
				m >>= 1;
			end
		end
		return (64'd16 << 16) - ((longint'(e) << 16) | frac);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// cos/sin of x/16384 quarter turn, Taylor in Q30, rounded to Q16
	function automatic void taylor_q16(input int unsigned x, output longint unsigned c,
		output longint unsigned s);
		longint unsigned th, t2, t3, t4, t5, t6, t7, t8;
		longint sv, cv;
		th = longint'(x) * 102944;
		t2 = (th * th) >> 30;
		t3 = (t2 * th) >> 30;
		t4 = (t2 * t2) >> 30;
		t5 = (t4 * th) >> 30;
		t6 = (t4 * t2) >> 30;
		t7 = (t6 * th) >> 30;
		t8 = (t4 * t4) >> 30;
		sv = longint'(th) - longint'(t3 / 6) + longint'(t5 / 120) - longint'(t7 / 5040);
		cv = (64'sd1 <<< 30) - longint'(t2 / 2) + longint'(t4 / 24) - longint'(t6 / 720)
			+ longint'(t8 / 40320);
		if (sv < 0) sv = 0;
		if (cv < 0) cv = 0;
		s = (longint'(sv) + 8192) >> 14;
		c = (longint'(cv) + 8192) >> 14;
	endfunction

	function automatic longint scaled(input longint unsigned r, input longint unsigned t,
		input bit neg);
		longint unsigned p;
		longint m;
		p = r * t * longint'(scale_shadow);
		m = longint'((p + (64'd1 << (NSHIFT - 1))) >> NSHIFT);
		return neg ? -m : m;
	endfunction

	function automatic longint sat(input longint v);
		if (v > S_MAX) return S_MAX;
		if (v < S_MIN) return S_MIN;
		return v;
	endfunction

	function automatic longint tx_level(input int sg, input bit [2:0] ph);
		return sg * (ph[0] ? HROOT : ONE_S);
	endfunction

	// one symbol through modem, channel and detector; false when dropped
	function automatic bit predict_symbol(input symbol_t it, output decision_t d);
		bit [2:0] step;
		bit [1:0] quad;
		int unsigned rem;
		longint unsigned radius, c, s, ca, sa;
		bit cneg, sneg;
		longint ni, nq, rxi, rxq, re, im;
		bit di, dq;
		int unsigned se;
		d = '{default: '0};
		if (it.ua == 0 || it.ub == 0)
			return 1'b0;
		if (it.nr) begin
			phase_acc = 0;
			last_rxi = ONE_S;
			last_rxq = 0;
			err_count = 0;
		end
		step = it.bi ? (it.bq ? STEP_P45 : STEP_M45) : (it.bq ? STEP_P135 : STEP_M135);
		phase_acc = phase_acc + step;

		radius = int_sqrt(((neg_log2(it.ua) * 90852) >> 16) << 16);
		quad = it.ub[15:14];
		rem = it.ub[13:0];
		if (rem > 8192)
			taylor_q16(16384 - rem, s, c);
		else
			taylor_q16(rem, c, s);
		case (quad)
			2'd0: begin ca = c; cneg = 0; sa = s; sneg = 0; end
			2'd1: begin ca = s; cneg = 1; sa = c; sneg = 0; end
			2'd2: begin ca = c; cneg = 1; sa = s; sneg = 1; end
			default: begin ca = s; cneg = 0; sa = c; sneg = 1; end
		endcase
		ni = scaled(radius, ca, cneg);
		nq = scaled(radius, sa, sneg);

		rxi = sat(tx_level(cos_sgn[phase_acc], phase_acc) + ni);
		rxq = sat(tx_level(sin_sgn[phase_acc], phase_acc) + nq);
		re = rxi * last_rxi + rxq * last_rxq;
		im = rxq * last_rxi - rxi * last_rxq;
		di = (re >= 0);
		dq = (im >= 0);
		se = (di != it.bi) + (dq != it.bq);
		err_count = (err_count > C_MAX - se) ? C_MAX : err_count + se;
		last_rxi = rxi;
		last_rxq = rxq;

		d.rxi = rxi[SW-1:0];
		d.rxq = rxq[SW-1:0];
		d.di = di;
		d.dq = dq;
		d.serr = se[1:0];
		d.total = err_count[CW-1:0];
		return 1'b1;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic symbol_t rand_symbol();
		symbol_t it;
		int unsigned k;
		it.bi = 1'($urandom_range(0, 1));
		it.bq = 1'($urandom_range(0, 1));
		k = $urandom_range(0, 99);
		// small radius uniforms give the heavy noise tail
		if (k < 3)       it.ua = 16'd0;
		else if (k < 20) it.ua = 16'($urandom_range(1, 255));
		else             it.ua = 16'($urandom_range(1, 65535));
		it.ub = ($urandom_range(0, 99) < 3) ? 16'd0 : 16'($urandom_range(1, 65535));
		it.nr = ($urandom_range(0, 39) == 0);
		return it;
	endfunction

	function automatic symbol_t mk(input bit bi, input bit bq, input bit [15:0] ua,
		input bit [15:0] ub, input bit nr);
		symbol_t it;
		it.bi = bi; it.bq = bq; it.ua = ua; it.ub = ub; it.nr = nr;
		return it;
	endfunction

	// unit must be idle: all results out, plus the front end's dropped-item time
	task automatic wait_idle();
		while (pending_syms.size() != 0 || rx_expected.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_scale(input int unsigned v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_NOISE_SCALE, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		scale_shadow = v & 32'hFFFF;   // written at this edge
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// ---------------- sequence ----------------
	initial begin
		int unsigned scales[6];
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.bit_i = 1'b0; in_ch.bit_q = 1'b0;
		in_ch.uniform_a = '0; in_ch.uniform_b = '0; in_ch.new_run = 1'b0;
		out_ch.ready = 1'b0;
		failed = 1'b0;
		scale_shadow = NOISE_SCALE_RST;
		phase_acc = 0; last_rxi = ONE_S; last_rxq = 0; err_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: all four steps, uniform extremes, quadrant and fold edges, drops
		pending_syms.push_back(mk(1, 1, 16'd65535, 16'd1, 0));
		pending_syms.push_back(mk(0, 1, 16'd1, 16'd65535, 0));
		pending_syms.push_back(mk(0, 0, 16'd32768, 16'd16384, 0));
		pending_syms.push_back(mk(1, 0, 16'd65535, 16'd32768, 0));
		pending_syms.push_back(mk(1, 1, 16'd0, 16'd1000, 1));      // dropped, new_run too
		pending_syms.push_back(mk(0, 1, 16'd1000, 16'd0, 1));      // dropped
		pending_syms.push_back(mk(1, 0, 16'd2, 16'd49152, 0));
		pending_syms.push_back(mk(0, 0, 16'd40000, 16'd8192, 0));
		pending_syms.push_back(mk(1, 1, 16'd40000, 16'd8193, 1));  // restart run
		pending_syms.push_back(mk(0, 1, 16'd3, 16'd16383, 0));
		pending_syms.push_back(mk(1, 0, 16'd65535, 16'd24577, 0));
		pending_syms.push_back(mk(0, 0, 16'd1, 16'd40960, 0));
		pending_syms.push_back(mk(1, 1, 16'd255, 16'd57344, 0));
		wait_idle();

		// zero noise: clean constellation, exact phase walk
		write_scale(0);
		for (int i = 0; i < 10; i++)
			pending_syms.push_back(mk(i[0], i[1], 16'($urandom_range(1, 65535)),
				16'($urandom_range(1, 65535)), i == 5));
		wait_idle();

		scales = '{32768, 65535, 1, 12000, 4000, 0};
		scales[5] = $urandom_range(0, 65535);
		foreach (scales[p]) begin
			write_scale(scales[p]);
			for (int i = 0; i < 210; i++)
				pending_syms.push_back(rand_symbol());
			wait_idle();
		end

		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ---------------- driver: bursts with random gaps ----------------
	int unsigned burst_left, gap_left;

	always @(posedge clk) begin
		symbol_t it;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left = $urandom_range(1, 8);
			gap_left = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left > 0) begin
				in_ch.valid <= 1'b0;
				gap_left--;
			end else if (pending_syms.size() != 0) begin
				it = pending_syms.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.bit_i <= it.bi;
				in_ch.bit_q <= it.bq;
				in_ch.uniform_a <= it.ua;
				in_ch.uniform_b <= it.ub;
				in_ch.new_run <= it.nr;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 8);
					// gaps up to beyond one item's processing time
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------- monitor: accept prediction, result check ----------------
	int unsigned stall_mode, mode_left;

	always @(posedge clk) begin
		symbol_t it;
		decision_t d, e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				it = mk(in_ch.bit_i, in_ch.bit_q, in_ch.uniform_a, in_ch.uniform_b,
					in_ch.new_run);
				if (predict_symbol(it, d))
					rx_expected.push_back(d);
			end

			if (out_ch.valid && out_ch.ready) begin
				if (rx_expected.size() == 0) begin
					$error("result with nothing expected");
					failed = 1'b1;
				end else begin
					e = rx_expected.pop_front();
					if (out_ch.rx_i !== e.rxi) begin
						$error("rx_i exp %0d got %0d", e.rxi, out_ch.rx_i); failed = 1'b1;
					end
					if (out_ch.rx_q !== e.rxq) begin
						$error("rx_q exp %0d got %0d", e.rxq, out_ch.rx_q); failed = 1'b1;
					end
					if (out_ch.decided_i !== e.di) begin
						$error("decided_i exp %0d got %0d", e.di, out_ch.decided_i);
						failed = 1'b1;
					end
					if (out_ch.decided_q !== e.dq) begin
						$error("decided_q exp %0d got %0d", e.dq, out_ch.decided_q);
						failed = 1'b1;
					end
					if (out_ch.symbol_errors !== e.serr) begin
						$error("symbol_errors exp %0d got %0d", e.serr, out_ch.symbol_errors);
						failed = 1'b1;
					end
					if (out_ch.error_total !== e.total) begin
						$error("error_total exp %0d got %0d", e.total, out_ch.error_total);
						failed = 1'b1;
					end
				end
			end

			// stall pattern: free-running, coin flip, or mostly stalled
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 2000);
			end
			mode_left--;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if (!arst_n) begin
			cycle_cnt <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if (cycle_cnt > LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
